// ----- sv/mtc_pkg.sv -----
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types, character codes and the letter table of the Morse text codec.
// ----------------------------------------------------------------------------
package mtc_pkg;

	localparam int MAX_SYMBOLS = 4;
	localparam int JOB_DEPTH   = 2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;
	localparam logic [7:0] CH_NONE  = 8'h00;

	localparam int NUM_LETTERS = 26;

	// {length, code}, first symbol most significant, 1 is a dash
	localparam logic [7:0] LETTER_CODE [NUM_LETTERS] = '{
		8'h21, 8'h48, 8'h4A, 8'h34, 8'h10, 8'h42, 8'h36, 8'h40, 8'h20, 8'h47,
		8'h35, 8'h44, 8'h23, 8'h22, 8'h37, 8'h46, 8'h4D, 8'h32, 8'h30, 8'h11,
		8'h31, 8'h41, 8'h33, 8'h49, 8'h4B, 8'h4C
	};

	localparam logic [1:0] REG_DIRECTION = 2'd0;

	typedef enum logic [1:0] {
		JOB_SPACES,
		JOB_LETTER,
		JOB_CHAR
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [2:0] count;  // results of this job, 1 to 5
		logic [2:0] len;    // symbols of a letter
		logic [3:0] bits;   // dash bits of a letter
		logic [7:0] chr;    // decoded character
	} job_t;

	function automatic logic [7:0] decode_group(input logic [3:0] sym, input logic [2:0] len,
	                                            input logic invalid);
		logic [7:0] res;
		res = CH_NONE;
		if (!invalid && len != 3'd0 && len <= 3'(MAX_SYMBOLS)) begin
			for (int i = 0; i < NUM_LETTERS; i++) begin
				if (LETTER_CODE[i][6:4] == len && LETTER_CODE[i][3:0] == sym) begin
					res = CH_UP_A + 8'(i);
				end
			end
		end
		return res;
	endfunction

endpackage

// ----- sv/morse_text_codec_unit.sv -----
// ----------------------------------------------------------------------------
// morse_text_codec_unit
// Morse codec for letters A to Z over queue-style character streams.
// ----------------------------------------------------------------------------
// The front end takes one character a cycle while the job queue has room and
// keeps the pending decode group. The back end drives one result a cycle
// through a single output register while that register is empty or popped.
// An encoded letter gives two to five results, an encoded space three, a
// decode flush one and a dropped character or a buffered symbol none. The
// job queue lets the front end take new characters while the back end still
// expands earlier jobs. The direction register sits at byte address 0 of the
// configuration port.
module morse_text_codec_unit
	import mtc_pkg::*;
#(
	parameter int DEPTH = JOB_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_in,
	input  logic        end_of_text,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  char_out,
	output logic        last
);

	logic       direction_q;
	logic [1:0] reg_idx;
	logic       job_push;
	logic       job_full;
	logic       job_valid;
	logic       job_pop;
	job_t       wr_job;
	job_t       rd_job;

	assign pready  = 1'b1;
	assign reg_idx = {1'b0, paddr[2]};

	always_comb begin
		case (reg_idx)
			REG_DIRECTION: prdata = {31'd0, direction_q};
			default:       prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_idx == REG_DIRECTION) begin
			direction_q <= pwdata[0];
		end
	end

	mtc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.direction   (direction_q),
		.push        (push),
		.full        (full),
		.char_in     (char_in),
		.end_of_text (end_of_text),
		.job_full    (job_full),
		.job_push    (job_push),
		.job         (wr_job)
	);

	mtc_job_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_job  (wr_job),
		.q_full  (job_full),
		.rd_en   (job_pop),
		.q_valid (job_valid),
		.rd_job  (rd_job)
	);

	mtc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (rd_job),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.char_out  (char_out),
		.last      (last)
	);

endmodule

// ----- sv/mtc_front.sv -----
// ----------------------------------------------------------------------------
// mtc_front
// Accepts characters, keeps the pending decode group and turns each
// character that yields results into a result job for the back end.
// ----------------------------------------------------------------------------
module mtc_front
	import mtc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       direction,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_in,
	input  logic       end_of_text,
	input  logic       job_full,
	output logic       job_push,
	output job_t       job
);

	logic [3:0] sym_q;
	logic [2:0] len_q;
	logic       inv_q;

	logic       accept;
	logic       has_job;
	logic [3:0] sym_d;
	logic [2:0] len_d;
	logic       inv_d;
	logic [7:0] up;
	logic [4:0] idx;
	logic [7:0] code;
	logic       bad;

	assign full     = job_full;
	assign accept   = push && !job_full;
	assign job_push = accept && has_job;

	always_comb begin
		up = char_in;
		if (char_in >= CH_LO_A && char_in <= CH_LO_Z) begin
			up = char_in - CASE_GAP;
		end
		idx  = 5'(up - CH_UP_A);
		code = 8'h00;
		if (up >= CH_UP_A && up <= CH_UP_Z) begin
			code = LETTER_CODE[idx];
		end
		bad = (char_in != CH_DOT) && (char_in != CH_DASH);

		sym_d    = sym_q;
		len_d    = len_q;
		inv_d    = inv_q;
		has_job  = 1'b0;
		job      = '0;
		job.kind = JOB_CHAR;

		if (!direction) begin
			if (char_in == CH_SPACE) begin
				has_job   = 1'b1;
				job.kind  = JOB_SPACES;
				job.count = 3'd3;
			end else if (code != 8'h00) begin
				has_job   = 1'b1;
				job.kind  = JOB_LETTER;
				job.len   = code[6:4];
				job.bits  = code[3:0];
				job.count = code[6:4] + 3'd1;
			end
		end else begin
			if (char_in == CH_SPACE) begin
				// a space flushes; the end flag then sees an empty group
				if (len_q != 3'd0) begin
					has_job   = 1'b1;
					job.count = 3'd1;
					job.chr   = decode_group(sym_q, len_q, inv_q);
					sym_d     = '0;
					len_d     = '0;
					inv_d     = 1'b0;
				end
			end else begin
				if (len_q >= 3'(MAX_SYMBOLS)) begin
					inv_d = 1'b1;
				end else begin
					inv_d = inv_q || bad;
					sym_d = {sym_q[2:0], char_in == CH_DASH};
					len_d = len_q + 3'd1;
				end
				if (end_of_text) begin
					has_job   = 1'b1;
					job.count = 3'd1;
					job.chr   = decode_group(sym_d, len_d, inv_d);
					sym_d     = '0;
					len_d     = '0;
					inv_d     = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= '0;
			len_q <= '0;
			inv_q <= 1'b0;
		end else if (accept) begin
			sym_q <= sym_d;
			len_q <= len_d;
			inv_q <= inv_d;
		end
	end

endmodule

// ----- sv/mtc_job_queue.sv -----
// ----------------------------------------------------------------------------
// mtc_job_queue
// Small register queue of result jobs between front and back end.
// ----------------------------------------------------------------------------
module mtc_job_queue
	import mtc_pkg::*;
#(
	parameter int DEPTH = JOB_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic q_full,
	input  logic rd_en,
	output logic q_valid,
	output job_t rd_job
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_full  = count_q == CW'(DEPTH);
	assign q_valid = count_q != '0;
	assign rd_job  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/mtc_back.sv -----
// ----------------------------------------------------------------------------
// mtc_back
// Expands each job into its result characters, one a cycle while the output
// register is empty or popped, into that register.
// ----------------------------------------------------------------------------
module mtc_back
	import mtc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  job_t       job,
	output logic       job_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] char_out,
	output logic       last
);

	logic [2:0] k_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       valid_q;

	logic       emit;
	logic       is_last;
	logic [2:0] pos;
	logic [7:0] chr;

	assign empty    = !valid_q;
	assign char_out = char_q;
	assign last     = last_q;

	assign emit    = job_valid && (!valid_q || pop);
	assign is_last = k_q == job.count - 3'd1;
	assign job_pop = emit && is_last;

	always_comb begin
		pos = job.len - 3'd1 - k_q;
		case (job.kind)
			JOB_LETTER: begin
				if (k_q < job.len) begin
					chr = job.bits[pos[1:0]] ? CH_DASH : CH_DOT;
				end else begin
					chr = CH_SPACE;
				end
			end
			JOB_CHAR: chr = job.chr;
			default:  chr = CH_SPACE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= chr;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
				k_q     <= is_last ? 3'd0 : k_q + 3'd1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Morse text codec. Character items flow in through
// a push/full queue port and results drain through an empty/pop port, both
// sides gapped at random. A predictor tracks the direction register and the
// pending symbol group and queues the expected output characters for each
// accepted item. The monitor checks every result transfer against that queue.
// ----------------------------------------------------------------------------
module tb_top
	import mtc_pkg::*;
();

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;
	localparam int   RUN_LIMIT  = 200000;
	localparam int   SETTLE     = 16;
	localparam int   LONG_HOLD  = 300;

	typedef struct {
		logic [7:0] ch;
		logic       eot;
	} text_item_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} morse_out_t;

	string morse_tab [0:25] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--.."
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  char_in = '0;
	logic        end_of_text = 1'b0;
	logic        pop = 1'b0;
	logic        empty;
	logic [7:0]  char_out;
	logic        last;

	// stimulus and expectations
	text_item_t  text_q [$];
	morse_out_t  out_char_q [$];
	int          send_idle = 36;
	int          recv_idle = 71;
	logic        rx_hold = 1'b0;
	bit          stall_go = 1'b0;
	int          n_bad = 0;
	int          cycle = 0;

	// predictor state
	logic        cfg_dir = DIR_ENCODE;
	logic [3:0]  grp_sym = '0;
	logic [2:0]  grp_len = '0;
	logic        grp_bad = 1'b0;

	morse_text_codec_unit uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .char_in(char_in), .end_of_text(end_of_text),
		.pop(pop), .empty(empty), .char_out(char_out), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= RUN_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [3:0] dash_bits(input string code);
		logic [3:0] b;
		b = '0;
		for (int k = 0; k < code.len(); k++)
			b = {b[2:0], code[k] == CH_DASH};
		return b;
	endfunction

	// decode the pending group and empty it
	function automatic logic [7:0] take_group();
		logic [7:0] letter;
		letter = CH_NONE;
		if (!grp_bad && grp_len != 3'd0) begin
			for (int i = 0; i < 26; i++) begin
				if (morse_tab[i].len() == int'(grp_len) && dash_bits(morse_tab[i]) == grp_sym)
					letter = CH_UP_A + 8'(i);
			end
		end
		grp_sym = '0;
		grp_len = '0;
		grp_bad = 1'b0;
		return letter;
	endfunction

	task automatic add_expect(input logic [7:0] ch);
		out_char_q.insert(out_char_q.size(), morse_out_t'{ch, 1'b0});
	endtask

	task automatic codec_step(input logic [7:0] ch, input logic eot);
		int         base;
		logic [7:0] up;
		string      code;
		base = out_char_q.size();
		if (cfg_dir == DIR_ENCODE) begin
			if (ch == CH_SPACE) begin
				repeat (3) add_expect(CH_SPACE);
			end else begin
				up = (ch >= CH_LO_A && ch <= CH_LO_Z) ? ch - CASE_GAP : ch;
				if (up >= CH_UP_A && up <= CH_UP_Z) begin
					code = morse_tab[up - CH_UP_A];
					for (int k = 0; k < code.len(); k++)
						add_expect(code[k]);
					add_expect(CH_SPACE);
				end
			end
		end else begin
			if (ch == CH_SPACE) begin
				if (grp_len != 3'd0)
					add_expect(take_group());
			end else if (grp_len >= 3'(MAX_SYMBOLS)) begin
				grp_bad = 1'b1;
			end else begin
				if (ch != CH_DOT && ch != CH_DASH)
					grp_bad = 1'b1;
				grp_sym = {grp_sym[2:0], ch == CH_DASH};
				grp_len = grp_len + 3'd1;
			end
			if (eot && grp_len != 3'd0)
				add_expect(take_group());
		end
		if (out_char_q.size() > base)
			out_char_q[out_char_q.size() - 1].last = 1'b1;
	endtask

	// sender: hold an item until it transfers, then maybe load the next
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				codec_step(char_in, end_of_text);
			if (!push || !full) begin
				if (text_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					char_in     <= text_q[0].ch;
					end_of_text <= text_q[0].eot;
					push        <= 1'b1;
					void'(text_q.pop_front());
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	task automatic flag_error(input string what, input logic [7:0] want, input logic [7:0] got);
		if (n_bad < 10)
			$display("mismatch on %s at cycle %0d: expected %h, got %h", what, cycle, want, got);
		n_bad++;
	endtask

	// receiver: check each result transfer against the oldest expectation
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (out_char_q.size() == 0) begin
					flag_error("unexpected result", CH_NONE, char_out);
				end else begin
					if (char_out !== out_char_q[0].ch)
						flag_error("char_out", out_char_q[0].ch, char_out);
					if (last !== out_char_q[0].last)
						flag_error("last", 8'(out_char_q[0].last), 8'(last));
					void'(out_char_q.pop_front());
				end
			end
			pop <= !rx_hold && ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// long receiver hold-off so the block backs up and raises full
	initial begin
		wait (stall_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic add_item(input logic [7:0] ch, input logic eot);
		text_q.insert(text_q.size(), text_item_t'{ch, eot});
	endtask

	task automatic add_string(input string s);
		for (int k = 0; k < s.len(); k++)
			add_item(s[k], 1'b0);
	endtask

	// wait until the block has drained, plus a margin for silent items
	task automatic settle();
		do begin
			while (text_q.size() != 0 || push || out_char_q.size() != 0)
				@(posedge clk);
			repeat (SETTLE) @(posedge clk);
		end while (text_q.size() != 0 || push || out_char_q.size() != 0);
	endtask

	task automatic set_direction(input logic dir);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(4 * REG_DIRECTION);
		pwdata  <= 32'(dir);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		cfg_dir = dir;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(cfg_dir))
			flag_error("direction readback", 8'(cfg_dir), prdata[7:0]);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic gen_text(input int n);
		logic [7:0] ch;
		int         pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				ch = (pick < 30 ? CH_UP_A : CH_LO_A) + 8'($urandom_range(0, 25));
			else if (pick < 75)
				ch = CH_SPACE;
			else
				ch = 8'($urandom_range(0, 255));
			add_item(ch, $urandom_range(0, 7) == 0);
		end
	endtask

	function automatic logic [7:0] bad_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == CH_SPACE || b == CH_DOT || b == CH_DASH);
		return b;
	endfunction

	// mostly well-formed letter groups, with noise and broken groups mixed in
	task automatic gen_symbols(input int n);
		int    stop;
		int    pick;
		int    glen;
		int    pos;
		string code;
		stop = text_q.size() + n;
		while (text_q.size() < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				code = morse_tab[$urandom_range(0, 25)];
				if ($urandom_range(0, 4) == 0) begin
					for (int k = 0; k < code.len(); k++)
						add_item(code[k], k == code.len() - 1);
				end else begin
					add_string(code);
					add_item(CH_SPACE, $urandom_range(0, 9) == 0);
				end
			end else if (pick < 88) begin
				glen = (pick < 70) ? $urandom_range(1, 4) : $urandom_range(1, 7);
				if (pick >= 70 && pick < 78)
					glen = $urandom_range(5, 7);
				pos = (pick >= 78) ? $urandom_range(0, glen - 1) : -1;
				for (int k = 0; k < glen; k++)
					add_item(k == pos ? bad_byte() : ($urandom_range(0, 1) ? CH_DASH : CH_DOT),
					         1'b0);
				add_item(CH_SPACE, $urandom_range(0, 9) == 0);
			end else if (pick < 95) begin
				repeat ($urandom_range(1, 3)) add_item(CH_SPACE, $urandom_range(0, 5) == 0);
			end else begin
				add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed encode: letter extremes, both cases, spaces, dropped bytes
		set_direction(DIR_ENCODE);
		add_string("AZazETQ");
		add_item(CH_SPACE, 1'b0);
		add_item(CH_SPACE, 1'b1);
		add_item(8'h00, 1'b0);
		add_item(8'hFF, 1'b1);
		add_item(8'h80, 1'b0);
		add_string(".@[`{");
		add_item("Y", 1'b1);
		settle();

		// directed decode
		set_direction(DIR_DECODE);
		add_string(".- ");
		add_string("--.");
		add_item(CH_DOT, 1'b1);      // flush on end of text
		add_string("---- ");         // no letter has this code
		add_string("..... ");        // overlong group
		add_string("x ");            // bad symbol
		add_item(8'h80, 1'b1);       // non-ASCII symbol, flushed by the flag
		add_item(CH_SPACE, 1'b0);    // space with no group pending
		add_item(CH_DOT, 1'b0);
		add_item(CH_SPACE, 1'b1);    // space flushes, flag finds nothing
		add_string("-.");            // keep this group across the mode change
		settle();

		set_direction(DIR_ENCODE);
		gen_text(80);
		settle();
		set_direction(DIR_DECODE);
		gen_symbols(85);
		settle();

		send_idle = 71;
		recv_idle = 36;
		set_direction(DIR_ENCODE);
		gen_text(50);
		settle();
		set_direction(DIR_DECODE);
		gen_symbols(50);
		settle();

		send_idle = 0;
		recv_idle = 0;
		set_direction(DIR_ENCODE);
		stall_go = 1'b1;
		gen_text(35);
		settle();
		set_direction(DIR_DECODE);
		gen_symbols(35);
		settle();

		if (n_bad == 0 && out_char_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
